[rtl/core/b64_pkg.sv]
`timescale 1ns / 1ps
package b64_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'

    // one queued job: up to three results, bytes packed from the top
    typedef struct packed {
        logic [23:0] bytes;
        logic [1:0]  cnt_m1;
        logic        has;
        logic        last;
    } t_rec;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sextet;

    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet r;
        r.ok  = 1'b1;
        r.val = 6'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            r.val = 6'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin
            r.val = 6'(c - 8'h61 + 8'd26);
        end else if (c inside {[8'h30:8'h39]}) begin
            r.val = 6'(c - 8'h30 + 8'd52);
        end else if (c == CHAR_PLUS) begin
            r.val = 6'd62;
        end else if (c == CHAR_SLASH) begin
            r.val = 6'd63;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

[rtl/core/b64_if.sv]
`timescale 1ns / 1ps
interface b64_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       last;

    modport source (output valid, output char_in, output last, input ready);
    modport sink   (input valid, input char_in, input last, output ready);
endinterface

interface b64_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output has_byte,
                    output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input has_byte,
                    input end_of_stream, output ready);
endinterface

[rtl/core/base64_stream_decoder.sv]
`timescale 1ns / 1ps
// channel | dir | payload                               | handshake
// i_in    | in  | char_in[7:0], last                    | valid/ready
// o_out   | out | data_byte[7:0], has_byte, end_of_stream | valid/ready
//
// One character per clock is accepted while the job queue has room.
// The output stage sends one result per clock from registered outputs while o_out.ready
// is high; a character's first result passes through the queue and then the output register.
// Sync active-low reset clears decode state, queue pointers and output valid.
// Output stalls back up through the queue to i_in.ready only when it fills.
module base64_stream_decoder #(
    parameter int QueueDepth = b64_pkg::QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    b64_in_if.sink    i_in,
    b64_out_if.source o_out
);
    import b64_pkg::*;

    logic w_push, w_full, w_pop, w_q_valid;
    t_rec w_rec_in, w_rec_out;

    b64_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_rec   (w_rec_in)
    );

    b64_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_rec   (w_rec_out)
    );

    b64_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_rec     (w_rec_out),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

    a_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.has_byte |-> o_out.end_of_stream && o_out.data_byte == 8'd0)
        else $error("end marker malformed");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_valid && (!o_out.valid || o_out.ready) |=> o_out.valid)
        else $error("queued job not moved to output");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid && !w_q_valid)
        else $error("output or queue active after reset");

    a_pop_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from empty queue");

endmodule

[rtl/core/b64_front.sv]
`timescale 1ns / 1ps
module b64_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    b64_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output b64_pkg::t_rec o_rec
);
    import b64_pkg::*;

    logic [1:0]  r_gc, n_gc;
    logic [17:0] r_held, n_held;
    logic        r_stopped, n_stopped;
    t_sextet     w_sx;
    logic        w_acc;
    logic [1:0]  w_n;

    assign i_in.ready = !i_full;
    assign w_acc      = i_in.valid && !i_full;
    assign w_sx       = sextet_of(i_in.char_in);

    always_comb begin
        n_gc        = r_gc;
        n_held      = r_held;
        n_stopped   = r_stopped;
        o_rec.bytes = 24'd0;
        w_n         = 2'd0;
        if (!r_stopped) begin
            if (w_sx.ok) begin
                if (r_gc == 2'd3) begin
                    o_rec.bytes = {r_held, w_sx.val};
                    w_n         = 2'd3;
                    n_gc        = 2'd0;
                    n_held      = 18'd0;
                end else begin
                    n_held = {r_held[11:0], w_sx.val};
                    n_gc   = r_gc + 2'd1;
                end
            end else begin
                n_stopped = 1'b1;
            end
        end
        if (i_in.last) begin
            // partial group flush; only reached when no full group was emitted
            if (n_gc == 2'd2) begin
                o_rec.bytes = {n_held[11:4], 16'd0};
                w_n         = 2'd1;
            end else if (n_gc == 2'd3) begin
                o_rec.bytes = {n_held[17:10], n_held[9:2], 8'd0};
                w_n         = 2'd2;
            end
            n_gc      = 2'd0;
            n_held    = 18'd0;
            n_stopped = 1'b0;
        end
        o_rec.has    = (w_n != 2'd0);
        o_rec.cnt_m1 = (w_n == 2'd0) ? 2'd0 : w_n - 2'd1;
        o_rec.last   = i_in.last;
    end

    assign o_push = w_acc && ((w_n != 2'd0) || i_in.last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gc      <= 2'd0;
            r_held    <= 18'd0;
            r_stopped <= 1'b0;
        end else if (w_acc) begin
            r_gc      <= n_gc;
            r_held    <= n_held;
            r_stopped <= n_stopped;
        end
    end

endmodule

[rtl/core/b64_fifo.sv]
`timescale 1ns / 1ps
module b64_fifo #(
    parameter int Depth = b64_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  b64_pkg::t_rec i_rec,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output b64_pkg::t_rec o_rec
);
    import b64_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] Full    = CntW'(Depth);

    t_rec            r_mem [Depth];
    logic [PtrW-1:0] r_wp, r_rp;
    logic [CntW-1:0] r_cnt;
    logic            w_wr, w_rd;

    assign o_full  = (r_cnt == Full);
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == LastPtr) ? '0 : r_wp + PtrW'(1);
            end
            if (w_rd) begin
                r_rp <= (r_rp == LastPtr) ? '0 : r_rp + PtrW'(1);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + CntW'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - CntW'(1);
            end
        end
    end

endmodule

[rtl/core/b64_back.sv]
`timescale 1ns / 1ps
module b64_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  b64_pkg::t_rec i_rec,
    output logic          o_pop,
    b64_out_if.source     o_out
);
    import b64_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_has;
    logic       r_eos;
    logic       w_take;
    logic       w_end;
    logic [7:0] w_byte;

    assign w_take = !r_valid || o_out.ready;
    assign w_end  = (r_idx == i_rec.cnt_m1);
    assign o_pop  = w_take && i_q_valid && w_end;

    always_comb begin
        case (r_idx)
            2'd0:    w_byte = i_rec.bytes[23:16];
            2'd1:    w_byte = i_rec.bytes[15:8];
            default: w_byte = i_rec.bytes[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (w_take) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                r_idx <= w_end ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_q_valid) begin
            r_byte <= w_byte;
            r_has  <= i_rec.has;
            r_eos  <= i_rec.last && w_end;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.data_byte     = r_byte;
    assign o_out.has_byte      = r_has;
    assign o_out.end_of_stream = r_eos;

endmodule

[dv/base64_stream_decoder_tb.sv]
`timescale 1ns / 1ps
module base64_stream_decoder_tb;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         drain;
    } char_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       eos;
    } byte_result_t;

    localparam int IDLE_PCT   = 34;
    localparam int STALL_LIMIT = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    b64_in_if  in_ch ();
    b64_out_if out_ch ();

    base64_stream_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #1 i_clk = ~i_clk;

    char_item_t   char_q[$];
    byte_result_t want_q[$];

    // decoder state mirror
    logic [1:0]  grp_cnt = '0;
    logic [17:0] held = '0;
    logic        halted = 1'b0;

    int unsigned n_in_xfer = 0;
    int unsigned errors = 0;
    int unsigned quiet_cycles = 0;
    logic        calm;

    assign calm = (n_in_xfer >= 150) && (n_in_xfer < 260);

    task automatic decode_char(input logic [7:0] ch, input logic last);
        logic [5:0]  sx;
        logic        ok;
        logic [23:0] w;
        logic [7:0]  got[$];
        ok = 1'b1;
        sx = 6'd0;
        if (!halted) begin
            if (ch >= "A" && ch <= "Z") sx = 6'(ch - "A");
            else if (ch >= "a" && ch <= "z") sx = 6'(ch - "a" + 26);
            else if (ch >= "0" && ch <= "9") sx = 6'(ch - "0" + 52);
            else if (ch == b64_pkg::CHAR_PLUS) sx = 6'd62;
            else if (ch == b64_pkg::CHAR_SLASH) sx = 6'd63;
            else ok = 1'b0;
            if (ok) begin
                if (grp_cnt == 2'd3) begin
                    w = {held, sx};
                    got.push_back(w[23:16]);
                    got.push_back(w[15:8]);
                    got.push_back(w[7:0]);
                    grp_cnt = 2'd0;
                    held = '0;
                end else begin
                    held = {held[11:0], sx};
                    grp_cnt = grp_cnt + 2'd1;
                end
            end else begin
                halted = 1'b1;
            end
        end
        if (last) begin
            if (grp_cnt == 2'd2) begin
                got.push_back(held[11:4]);
            end else if (grp_cnt == 2'd3) begin
                got.push_back(held[17:10]);
                got.push_back(held[9:2]);
            end
            grp_cnt = 2'd0;
            held = '0;
            halted = 1'b0;
            if (got.size() == 0) want_q.push_back('{8'h00, 1'b0, 1'b1});
        end
        foreach (got[i]) begin
            want_q.push_back('{got[i], 1'b1, last && (i == got.size() - 1)});
        end
    endtask

    function automatic logic [7:0] b64_char(input int idx);
        if (idx < 26) return 8'(8'h41 + idx);
        if (idx < 52) return 8'(8'h61 + idx - 26);
        if (idx < 62) return 8'(8'h30 + idx - 52);
        if (idx == 62) return b64_pkg::CHAR_PLUS;
        return b64_pkg::CHAR_SLASH;
    endfunction

    task automatic add_stream(input logic [7:0] chars[$], input bit drain);
        foreach (chars[i]) begin
            char_q.push_back('{chars[i], i == chars.size() - 1, drain && i == 0});
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid   <= 1'b0;
            in_ch.char_in <= 8'h00;
            in_ch.last    <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                decode_char(in_ch.char_in, in_ch.last);
                n_in_xfer <= n_in_xfer + 1;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (char_q.size() > 0 && (!char_q[0].drain || want_q.size() == 0)
                    && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    in_ch.valid   <= 1'b1;
                    in_ch.char_in <= char_q[0].ch;
                    in_ch.last    <= char_q[0].last;
                    void'(char_q.pop_front());
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        byte_result_t exp_r;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (want_q.size() == 0) begin
                    $display("%0t: unexpected transfer data=%h has=%b eos=%b", $time,
                             out_ch.data_byte, out_ch.has_byte, out_ch.end_of_stream);
                    errors <= errors + 1;
                end else begin
                    exp_r = want_q.pop_front();
                    if (exp_r.data !== out_ch.data_byte || exp_r.has !== out_ch.has_byte
                        || exp_r.eos !== out_ch.end_of_stream) begin
                        $display("%0t: mismatch expected data=%h has=%b eos=%b,",
                                 $time, exp_r.data, exp_r.has, exp_r.eos,
                                 " got data=%h has=%b eos=%b",
                                 out_ch.data_byte, out_ch.has_byte, out_ch.end_of_stream);
                        errors <= errors + 1;
                    end
                end
            end
            out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("base64_stream_decoder_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [7:0] s[$];
        int unsigned n_rand;
        int kind, len, pos;
        bit drain;

        i_rst_n <= 1'b0;

        // directed: full groups over every alphabet class, end on a group boundary
        add_stream('{"T", "W", "F", "u", "/", "+", "9", "z"}, 1'b0);
        add_stream('{"A", "A"}, 1'b0);                      // two sextets -> one byte
        add_stream('{"A"}, 1'b0);                           // single sextet -> end marker
        add_stream('{"/", "/", "=", "Z", "="}, 1'b0);       // pad stops, rest ignored
        add_stream('{8'hFF, 8'h00}, 1'b0);                  // invalid at start -> marker
        add_stream('{"0", "9", "a"}, 1'b0);                 // three sextets -> two bytes
        add_stream('{8'h40}, 1'b0);                         // invalid char with last
        add_stream('{"/", "/", "/", "/", 8'h5B}, 1'b0);     // full group then invalid last

        n_rand = 0;
        while (n_rand < 320) begin
            s = {};
            kind = $urandom_range(9);
            len = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
            drain = (n_rand == 0) || ($urandom_range(15) == 0);
            if (kind <= 6) begin
                for (int i = 0; i < len; i++) s.push_back(b64_char($urandom_range(63)));
                if ($urandom_range(1) == 1) begin
                    while (s.size() % 4 != 0) s.push_back(b64_pkg::CHAR_PAD);
                end
            end else if (kind <= 8) begin
                for (int i = 0; i < len; i++) s.push_back(b64_char($urandom_range(63)));
                pos = $urandom_range(len);
                s.insert(pos, 8'($urandom_range(255)));
            end else begin
                for (int i = 0; i < len; i++) s.push_back(8'($urandom_range(255)));
            end
            add_stream(s, drain);
            n_rand += s.size();
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (char_q.size() > 0 || in_ch.valid || want_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (errors == 0) begin
            $display("base64_stream_decoder_tb OK");
        end else begin
            $display("base64_stream_decoder_tb NOT OK");
        end
        $finish;
    end

endmodule
